>>> rtl/core/flux_write_precompensation_core_macros.svh
// Assertion macros shared by the checker files of the precompensation core.
// Every property is sampled on clk_i and is switched off while rst_ni is low.
`ifndef FLUX_WRITE_PRECOMPENSATION_CORE_MACROS_SVH
`define FLUX_WRITE_PRECOMPENSATION_CORE_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define FWP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition never holds.
`define FWP_ASSERT_NEVER(lbl, cond, msg) \
  `FWP_ASSERT(lbl, !(cond), msg)

`endif

>>> rtl/core/fwp_pkg.sv
`default_nettype none

package fwp_pkg;

  // Table sizes.
  localparam int MaxBands = 8;
  localparam int BandW    = $clog2(MaxBands);
  localparam int CntW     = $clog2(MaxBands + 1);
  localparam int RunDepth = 128;
  localparam int RunIdxW  = $clog2(RunDepth);
  localparam int PairW    = 2 * BandW;

  // Interval limits in 7.8 counter units.
  localparam int MinInterval = 32'h0300;
  localparam int MaxInterval = 32'h7fff;
  localparam int FracW       = 8;

  // Band count after reset.
  localparam logic [3:0] BandCountReset = 4'd8;

  // Word kinds.
  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_BAND  = 2'd1,
    KIND_SHIFT = 2'd2
  } kind_e;

  // Input word.
  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         run_length;
    logic [2:0]         band;
    logic [2:0]         next_band;
    logic [14:0]        write_interval;
    logic signed [15:0] shift_value;
  } fwp_in_t;

  // Result word.
  typedef struct packed {
    logic        has_byte;
    logic [6:0]  counter_byte;
    logic        clipped;
    logic        invalid_run;
    logic [15:0] invalid_total;
  } fwp_out_t;

  // Control carried into the interval stage.
  typedef struct packed {
    logic is_data;
    logic inv;
  } fwp_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/core/flux_write_precompensation_core.sv
// Channel   Dir  Handshake           Word
// in        in   in_valid_i/stall_o  fwp_in_t: data run, band load or shift load
// out       out  out_valid_o/stall_i fwp_out_t: one result per input word
// cfg       in   cfg_valid_i/ready_o band_count, 4 bits; ready is always high
//
// One word is accepted per cycle while in_stall_o is low; its result passes through
// the stage one, stage two and result registers. The pipeline holds two dependent RAM reads:
// the band map, then the interval and shift tables addressed by the band found.
// Reset clears the map valid bits, accumulator, previous band and counter at once;
// there is no clearing pass. The interval and shift tables hold no reset value.
// An output stall holds the result register and backs up into in_stall_o.
`default_nettype none

module flux_write_precompensation_core import fwp_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire fwp_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output fwp_out_t      out_data_o,
  input  wire logic     cfg_valid_i,
  output logic          cfg_ready_o,
  input  wire logic [3:0] cfg_data_i
);

  // Flow control.
  logic out_ready, s2_adv, s2_free, s1_adv, s1_free, in_acc;
  logic v1_q, v2_q, out_valid_q;
  logic [1:0] kind1_q;
  fwp_ctrl_t ctrl2_q, ctrl1;
  fwp_out_t  out_data_q, res;

  // Configuration.
  logic [3:0] band_count_q;
  logic [CntW-1:0] in_use;

  // Load decode.
  logic band_ok, next_ok, run_ok, map_we, ivl_we, shf_we;
  logic [RunIdxW-1:0] rd_idx;

  // Band resolve.
  logic [BandW-1:0] map_band, cur, prev_band_q;
  logic             map_valid, map_ok, tab_re;
  logic [14:0]        interval;
  logic signed [15:0] shift;

  assign out_ready = !out_valid_q || !out_stall_i;
  assign s2_adv    = v2_q && out_ready;
  assign s2_free   = !v2_q || out_ready;
  assign s1_adv    = v1_q && s2_free;
  assign s1_free   = !v1_q || s2_free;
  assign in_stall_o = !s1_free;
  assign in_acc    = in_valid_i && s1_free;

  // Configuration register; the user must write it only while idle, the block does not enforce this.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_count_q <= BandCountReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      band_count_q <= cfg_data_i;
    end
  end

  // Bands in use: zero reads as one, large values as the table size.
  always_comb begin
    if (band_count_q == 4'd0) begin
      in_use = CntW'(1);
    end else if (int'(band_count_q) > MaxBands) begin
      in_use = CntW'(MaxBands);
    end else begin
      in_use = CntW'(band_count_q);
    end
  end

  // Table writes happen when the load word is accepted.
  assign band_ok = int'(in_data_i.band) < MaxBands;
  assign next_ok = int'(in_data_i.next_band) < MaxBands;
  assign run_ok  = int'(in_data_i.run_length) < RunDepth;
  assign map_we  = in_acc && (in_data_i.kind == KIND_BAND) && band_ok && run_ok;
  assign ivl_we  = in_acc && (in_data_i.kind == KIND_BAND) && band_ok;
  assign shf_we  = in_acc && (in_data_i.kind == KIND_SHIFT) && band_ok && next_ok;

  // Data runs beyond the map read its last entry.
  assign rd_idx = run_ok ? in_data_i.run_length[RunIdxW-1:0] : RunIdxW'(RunDepth - 1);

  fwp_band_map u_band_map (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (map_we),
    .wr_idx_i   (in_data_i.run_length[RunIdxW-1:0]),
    .wr_band_i  (BandW'(in_data_i.band)),
    .rd_en_i    (in_acc && (in_data_i.kind == KIND_DATA)),
    .rd_idx_i   (rd_idx),
    .rd_band_o  (map_band),
    .rd_valid_o (map_valid)
  );

  // Stage one: resolve the band; unmapped or unused bands take the last band.
  assign map_ok = map_valid && ({1'b0, map_band} < in_use);
  assign cur    = map_ok ? map_band : BandW'(in_use - CntW'(1));
  assign ctrl1.is_data = (kind1_q == KIND_DATA);
  assign ctrl1.inv     = (kind1_q == KIND_DATA) && !map_ok;
  assign tab_re = s1_adv && ctrl1.is_data;

  // Previous band follows data words in order through stage one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_band_q <= '0;
    end else if (tab_re) begin
      prev_band_q <= cur;
    end
  end

  fwp_tables u_tables (
    .clk_i       (clk_i),
    .ivl_we_i    (ivl_we),
    .ivl_waddr_i (BandW'(in_data_i.band)),
    .ivl_wdata_i (in_data_i.write_interval),
    .shf_we_i    (shf_we),
    .shf_waddr_i ({BandW'(in_data_i.band), BandW'(in_data_i.next_band)}),
    .shf_wdata_i (in_data_i.shift_value),
    .re_i        (tab_re),
    .band_i      (cur),
    .pair_i      ({prev_band_q, cur}),
    .interval_o  (interval),
    .shift_o     (shift)
  );

  // Stage two: interval arithmetic.
  fwp_interval_calc u_calc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (s2_adv),
    .ctrl_i     (ctrl2_q),
    .interval_i (interval),
    .shift_i    (shift),
    .res_o      (res)
  );

  // Pipeline valid bits and stage control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_free) begin
        v1_q <= in_acc;
      end
      if (s2_free) begin
        v2_q <= s1_adv;
      end
      if (out_ready) begin
        out_valid_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind1_q <= in_data_i.kind;
    end
    if (s1_adv) begin
      ctrl2_q <= ctrl1;
    end
    if (s2_adv) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

>>> rtl/core/fwp_ram.sv
`default_nettype none

// Simple dual-port RAM with one write port and one registered read port.
module fwp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/core/fwp_band_map.sv
`default_nettype none

// Run length to band map: band codes in RAM, valid bits in flops.
module fwp_band_map import fwp_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               wr_en_i,
  input  wire logic [RunIdxW-1:0] wr_idx_i,
  input  wire logic [BandW-1:0]   wr_band_i,
  input  wire logic               rd_en_i,
  input  wire logic [RunIdxW-1:0] rd_idx_i,
  output logic      [BandW-1:0]   rd_band_o,
  output logic                    rd_valid_o
);

  logic [RunDepth-1:0] valid_q;
  logic                rd_valid_q;

  fwp_ram #(
    .Width (BandW),
    .Depth (RunDepth)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en_i),
    .waddr_i (wr_idx_i),
    .wdata_i (wr_band_i),
    .re_i    (rd_en_i),
    .raddr_i (rd_idx_i),
    .rdata_o (rd_band_o)
  );

  // Valid bits: all entries are unmapped after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_idx_i] <= 1'b1;
    end
  end

  // The valid bit is read alongside the RAM so both arrive together.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else if (rd_en_i) begin
      rd_valid_q <= valid_q[rd_idx_i];
    end
  end

  assign rd_valid_o = rd_valid_q;

endmodule

`default_nettype wire

>>> rtl/core/fwp_tables.sv
`default_nettype none

// Band interval table and band pair shift table.
module fwp_tables import fwp_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                ivl_we_i,
  input  wire logic [BandW-1:0]    ivl_waddr_i,
  input  wire logic [14:0]         ivl_wdata_i,
  input  wire logic                shf_we_i,
  input  wire logic [PairW-1:0]    shf_waddr_i,
  input  wire logic signed [15:0]  shf_wdata_i,
  input  wire logic                re_i,
  input  wire logic [BandW-1:0]    band_i,
  input  wire logic [PairW-1:0]    pair_i,
  output logic      [14:0]         interval_o,
  output logic signed [15:0]       shift_o
);

  logic [15:0] shift_raw;

  fwp_ram #(
    .Width (15),
    .Depth (MaxBands)
  ) u_interval_ram (
    .clk_i   (clk_i),
    .we_i    (ivl_we_i),
    .waddr_i (ivl_waddr_i),
    .wdata_i (ivl_wdata_i),
    .re_i    (re_i),
    .raddr_i (band_i),
    .rdata_o (interval_o)
  );

  fwp_ram #(
    .Width (16),
    .Depth (MaxBands * MaxBands)
  ) u_shift_ram (
    .clk_i   (clk_i),
    .we_i    (shf_we_i),
    .waddr_i (shf_waddr_i),
    .wdata_i (shf_wdata_i),
    .re_i    (re_i),
    .raddr_i (pair_i),
    .rdata_o (shift_raw)
  );

  assign shift_o = signed'(shift_raw);

endmodule

`default_nettype wire

>>> rtl/core/fwp_interval_calc.sv
`default_nettype none

// Accumulator, pair correction, saturation and the invalid run counter.
module fwp_interval_calc import fwp_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               adv_i,
  input  wire fwp_ctrl_t          ctrl_i,
  input  wire logic [14:0]        interval_i,
  input  wire logic signed [15:0] shift_i,
  output fwp_out_t                res_o
);

  logic [FracW-1:0]   frac_q, frac_d;
  logic signed [17:0] prev_q, prev_d;
  logic [15:0]        inv_cnt_q, inv_cnt_d;

  logic               emit;
  logic signed [18:0] frac_x, ival_x, shift_x, prev_x, acc_sum, corr;
  logic               clip;
  logic [6:0]         cbyte;

  // The previous interval is emitted only once it is positive.
  assign emit    = ctrl_i.is_data && (prev_q > 18'sd0);
  assign frac_x  = signed'({11'd0, frac_q});
  assign ival_x  = signed'({4'd0, interval_i});
  assign shift_x = emit ? {{3{shift_i[15]}}, shift_i} : 19'sd0;
  assign prev_x  = {prev_q[17], prev_q};

  // The shift moves from the previous interval into the current one.
  assign acc_sum = frac_x + ival_x + shift_x;
  assign corr    = prev_x - shift_x;

  // Saturate the corrected interval and keep its integer part.
  always_comb begin
    clip  = 1'b0;
    cbyte = corr[14:8];
    if (corr < 19'(MinInterval)) begin
      clip  = 1'b1;
      cbyte = 7'(MinInterval >> FracW);
    end else if (corr > 19'(MaxInterval)) begin
      clip  = 1'b1;
      cbyte = 7'(MaxInterval >> FracW);
    end
  end

  // Next state for a data word; other words leave it alone.
  always_comb begin
    frac_d    = frac_q;
    prev_d    = prev_q;
    inv_cnt_d = inv_cnt_q;
    if (ctrl_i.is_data) begin
      frac_d = acc_sum[FracW-1:0];
      prev_d = acc_sum[17:0];
      if (ctrl_i.inv && (inv_cnt_q != 16'hffff)) begin
        inv_cnt_d = inv_cnt_q + 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_q    <= '0;
      prev_q    <= '0;
      inv_cnt_q <= '0;
    end else if (adv_i) begin
      frac_q    <= frac_d;
      prev_q    <= prev_d;
      inv_cnt_q <= inv_cnt_d;
    end
  end

  // Result word.
  always_comb begin
    res_o.has_byte      = emit;
    res_o.counter_byte  = emit ? cbyte : 7'd0;
    res_o.clipped       = emit && clip;
    res_o.invalid_run   = ctrl_i.is_data && ctrl_i.inv;
    res_o.invalid_total = inv_cnt_d;
  end

endmodule

`default_nettype wire

>>> rtl/core/fwp_checker.sv
`default_nettype none

`include "flux_write_precompensation_core_macros.svh"

// Port-level checks on the result channel.
module fwp_checker import fwp_pkg::*; (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     out_valid_o,
  input wire logic     out_stall_i,
  input wire fwp_out_t out_data_o
);

  // A stalled result word stays put.
  `FWP_ASSERT(out_hold_a, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)), "stalled result changed")

  // Without a byte, the byte and clip fields are zero.
  `FWP_ASSERT_NEVER(idle_fields_a, out_valid_o && !out_data_o.has_byte && ((out_data_o.counter_byte != 7'd0) || out_data_o.clipped), "idle result carries a byte")

  // An emitted byte never falls below the minimum interval.
  `FWP_ASSERT_NEVER(min_byte_a, out_valid_o && out_data_o.has_byte && (out_data_o.counter_byte < 7'(MinInterval >> FracW)), "byte below minimum interval")

  // An invalid run is always counted.
  `FWP_ASSERT_NEVER(inv_count_a, out_valid_o && out_data_o.invalid_run && (out_data_o.invalid_total == 16'd0), "invalid run not counted")

  // The invalid count never goes down from one result to the next.
  `FWP_ASSERT(inv_mono_a, (out_valid_o && !out_stall_i) |=> (!out_valid_o || (out_data_o.invalid_total >= $past(out_data_o.invalid_total))), "invalid count decreased")

endmodule

bind flux_write_precompensation_core fwp_checker u_checker (.*);

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import fwp_pkg::*;

  // Word kind that the block must ignore.
  localparam logic [1:0] KindUnused = 2'd3;
  localparam int CycleLimit = 1_000_000;

  // Tracks the precompensation state and holds the result words still due.
  class flux_byte_scoreboard;
    logic [2:0] map_band [RunDepth];
    bit map_ok [RunDepth];
    logic [14:0] band_iv [MaxBands];
    bit iv_set [MaxBands];
    logic signed [15:0] pair_sh [MaxBands * MaxBands];
    bit sh_set [MaxBands * MaxBands];
    logic signed [17:0] acc = '0;
    logic signed [17:0] prev_iv = '0;
    logic [2:0] prev_band = '0;
    logic [15:0] inv_cnt = '0;
    logic [3:0] band_count = BandCountReset;
    fwp_out_t due_words [$];
    int errors = 0;
    int n_results = 0;
    int n_bytes = 0;
    int n_clipped = 0;
    int n_invalid = 0;

    function int pending();
      return due_words.size();
    endfunction

    // A band count of zero acts as one; counts above the table size are capped.
    function logic [3:0] bands_used();
      if (band_count == 4'd0) return 4'd1;
      if (band_count > MaxBands) return 4'(MaxBands);
      return band_count;
    endfunction

    // Long runs are clamped to the last map entry; unmapped runs and runs mapped
    // to a band outside the bands in use fall back to the last band in use.
    function void lookup(input logic [7:0] run, output logic [2:0] cur, output bit inv);
      logic [6:0] idx;
      logic [3:0] cnt;
      cnt = bands_used();
      idx = (run > RunDepth - 1) ? 7'(RunDepth - 1) : run[6:0];
      if (map_ok[idx] && map_band[idx] < cnt) begin
        cur = map_band[idx];
        inv = 1'b0;
      end else begin
        cur = 3'(cnt - 4'd1);
        inv = 1'b1;
      end
    endfunction

    // Applies one accepted input word and queues the result word it must cause.
    function void apply_word(input fwp_in_t w);
      fwp_out_t r;
      logic [2:0] cur;
      bit inv;
      logic signed [15:0] p;
      logic signed [17:0] val;
      r = '0;
      case (w.kind)
        KIND_BAND: begin
          if (w.run_length < RunDepth) begin
            map_band[w.run_length[6:0]] = w.band;
            map_ok[w.run_length[6:0]] = 1'b1;
          end
          band_iv[w.band] = w.write_interval;
          iv_set[w.band] = 1'b1;
        end
        KIND_SHIFT: begin
          pair_sh[{w.band, w.next_band}] = w.shift_value;
          sh_set[{w.band, w.next_band}] = 1'b1;
        end
        KIND_DATA: begin
          lookup(w.run_length, cur, inv);
          if (inv) begin
            r.invalid_run = 1'b1;
            if (inv_cnt != 16'hffff) inv_cnt = inv_cnt + 16'd1;
          end
          acc = acc + $signed({3'b000, band_iv[cur]});
          // The previous interval is emitted once the current band is known.
          if (prev_iv > 0) begin
            p = pair_sh[{prev_band, cur}];
            prev_iv = prev_iv - p;
            acc = acc + p;
            val = prev_iv;
            if (val < MinInterval) begin
              r.clipped = 1'b1;
              val = 18'(MinInterval);
            end
            if (val > MaxInterval) begin
              r.clipped = 1'b1;
              val = 18'(MaxInterval);
            end
            r.has_byte = 1'b1;
            r.counter_byte = val[14:8];
          end
          // Only the fraction carries into the next interval.
          prev_iv = acc;
          acc = {10'd0, acc[7:0]};
          prev_band = cur;
        end
        default: begin
        end
      endcase
      r.invalid_total = inv_cnt;
      due_words.push_back(r);
    endfunction

    task report(input string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    // Compares one accepted result word with the oldest one due.
    task check_word(input fwp_out_t got);
      fwp_out_t want;
      if (due_words.size() == 0) begin
        report($sformatf("result word %0d arrived with none due", n_results));
        return;
      end
      want = due_words.pop_front();
      if (got.has_byte !== want.has_byte)
        report($sformatf("word %0d has_byte %0b, want %0b", n_results, got.has_byte,
                         want.has_byte));
      if (got.counter_byte !== want.counter_byte)
        report($sformatf("word %0d counter_byte %0h, want %0h", n_results,
                         got.counter_byte, want.counter_byte));
      if (got.clipped !== want.clipped)
        report($sformatf("word %0d clipped %0b, want %0b", n_results, got.clipped,
                         want.clipped));
      if (got.invalid_run !== want.invalid_run)
        report($sformatf("word %0d invalid_run %0b, want %0b", n_results, got.invalid_run,
                         want.invalid_run));
      if (got.invalid_total !== want.invalid_total)
        report($sformatf("word %0d invalid_total %0h, want %0h", n_results,
                         got.invalid_total, want.invalid_total));
      n_results++;
      n_bytes += want.has_byte;
      n_clipped += want.clipped;
      n_invalid += want.invalid_run;
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  fwp_in_t in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  fwp_out_t out_data_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [3:0] cfg_data_i;

  flux_byte_scoreboard sb;
  bit idle_on;
  bit stall_on;
  int stall_left;
  int words_sent;
  int cycle_cnt;
  logic [3:0] phase_counts [8] = '{4'd3, 4'd0, 4'd15, 4'd1, 4'd9, 4'd6, 4'd2, 4'd8};

  flux_write_precompensation_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Receiver stalls in random bursts while enabled.
  always @(posedge clk_i) begin
    if (!stall_on) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left = $urandom_range(0, 4);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Every accepted result word is checked against the oldest one due.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_word(out_data_o);
  end

  // Watchdog on the whole run.
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles", cycle_cnt);
    $display("status: fail");
    $finish;
  end

  // Word builders; fields that the kind does not use carry random bits.
  function automatic fwp_in_t noise_word();
    logic [63:0] raw;
    fwp_in_t w;
    raw = {$urandom, $urandom};
    w = raw[$bits(fwp_in_t)-1:0];
    return w;
  endfunction

  function automatic fwp_in_t data_word(input logic [7:0] run);
    fwp_in_t w;
    w = noise_word();
    w.kind = KIND_DATA;
    w.run_length = run;
    return w;
  endfunction

  function automatic fwp_in_t band_word(input logic [7:0] run, input logic [2:0] band,
                                        input logic [14:0] iv);
    fwp_in_t w;
    w = noise_word();
    w.kind = KIND_BAND;
    w.run_length = run;
    w.band = band;
    w.write_interval = iv;
    return w;
  endfunction

  function automatic fwp_in_t shift_word(input logic [2:0] band, input logic [2:0] nband,
                                         input logic signed [15:0] s);
    fwp_in_t w;
    w = noise_word();
    w.kind = KIND_SHIFT;
    w.band = band;
    w.next_band = nband;
    w.shift_value = s;
    return w;
  endfunction

  function automatic fwp_in_t unused_word();
    fwp_in_t w;
    w = noise_word();
    w.kind = KindUnused;
    return w;
  endfunction

  // Mostly short runs that the map covers, sometimes any run, rarely clamped ones.
  function automatic logic [7:0] pick_run();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return 8'($urandom_range(0, 40));
    if (roll < 95) return 8'($urandom_range(0, 127));
    return 8'($urandom_range(128, 255));
  endfunction

  // Mostly realistic intervals, some below the floor, some anywhere.
  function automatic logic [14:0] pick_interval();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 15'($urandom_range(16'h0180, 16'h0c00));
    if (roll < 85) return 15'($urandom_range(0, 16'h0300));
    return 15'($urandom_range(0, 16'h7fff));
  endfunction

  function automatic logic signed [15:0] pick_shift();
    int v;
    if ($urandom_range(0, 99) < 75) v = $urandom_range(0, 256) - 128;
    else v = $urandom_range(0, 16'hffff);
    return 16'(v);
  endfunction

  // Offers one word and waits until the block takes it.
  task automatic send_word(input fwp_in_t w);
    in_valid_i <= 1'b1;
    in_data_i <= w;
    do @(posedge clk_i); while (in_stall_o);
    sb.apply_word(w);
    words_sent++;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  // A data word must never read an interval or shift entry that was never
  // loaded, so missing entries are loaded first. The band load uses a run
  // beyond the map, which leaves the map untouched.
  task automatic send_data(input logic [7:0] run);
    logic [2:0] cur;
    bit inv;
    sb.lookup(run, cur, inv);
    if (!sb.iv_set[cur])
      send_word(band_word(8'($urandom_range(128, 255)), cur, pick_interval()));
    if (sb.prev_iv > 0 && !sb.sh_set[{sb.prev_band, cur}])
      send_word(shift_word(sb.prev_band, cur, pick_shift()));
    send_word(data_word(run));
  endtask

  task automatic send_random();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70)
      send_data(pick_run());
    else if (roll < 85)
      send_word(band_word(pick_run(), 3'($urandom_range(0, 7)), pick_interval()));
    else if (roll < 96)
      send_word(shift_word(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                           pick_shift()));
    else
      send_word(unused_word());
  endtask

  // Waits until every result word due has arrived.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_band_count(input logic [3:0] value);
    drain();
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.band_count = value;
  endtask

  initial begin
    sb = new;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    idle_on = 1'b0;
    stall_on = 1'b0;
    stall_left = 0;
    words_sent = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words: field extremes, clamped and unmapped runs, both clip
    // directions, an ignored kind, and a band load that skips the map.
    send_word(band_word(8'd0, 3'd0, 15'h0400));
    send_word(band_word(8'd127, 3'd7, 15'h7fff));
    send_word(band_word(8'd255, 3'd3, 15'h0000));
    send_word(band_word(8'd20, 3'd5, 15'h0100));
    send_word(shift_word(3'd0, 3'd0, 16'sh8000));
    send_word(shift_word(3'd0, 3'd7, 16'sh7fff));
    send_word(shift_word(3'd7, 3'd0, 16'sh0000));
    send_word(shift_word(3'd7, 3'd7, 16'sh0000));
    send_data(8'd0);
    send_data(8'd0);
    send_data(8'd255);
    send_data(8'd127);
    send_data(8'd60);
    send_word(fwp_in_t'('1));
    send_data(8'd20);
    send_data(8'd20);
    send_data(8'd20);
    send_word(shift_word(3'd7, 3'd7, 16'sh7fff));
    send_data(8'd127);
    send_data(8'd127);
    send_word(unused_word());
    send_data(8'd0);

    // Random phases, each under its own band count.
    idle_on = 1'b1;
    stall_on = 1'b1;
    for (int i = 0; i < 24; i++)
      send_word(band_word(8'($urandom_range(0, 40)), 3'($urandom_range(0, 7)),
                          pick_interval()));
    foreach (phase_counts[ph]) begin
      write_band_count(phase_counts[ph]);
      for (int n = 0; n < 215; n++) begin
        if (n % 60 == 0) begin
          idle_on = ($urandom_range(0, 3) != 0);
          stall_on = ($urandom_range(0, 3) != 0);
        end
        send_random();
      end
    end

    // Last part, without idling: back-to-back data runs with a single band in use.
    write_band_count(4'd1);
    idle_on = 1'b0;
    stall_on = 1'b0;
    for (int n = 0; n < 40; n++)
      send_data(8'($urandom_range(0, 255)));

    drain();
    repeat (20) @(posedge clk_i);
    $display("sent %0d words, checked %0d results: %0d counter bytes, %0d clipped",
             words_sent, sb.n_results, sb.n_bytes, sb.n_clipped);
    $display("%0d invalid runs; band counts 0 to 15 incl. both ends; %0d mismatches",
             sb.n_invalid, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
